@@ src/apcf_pkg.sv @@
// Package for the box pair collision finder: transaction structs, field widths,
// result kinds and the command and status bundles between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package apcf_pkg;

    // Field widths of the input and result transactions.
    localparam int COORD_BITS  = 16;
    localparam int CENTRE_BITS = COORD_BITS + 1;
    localparam int SIZE_BITS   = 16;
    localparam int TYPE_BITS   = 8;
    localparam int SLOT_BITS   = 5;

    // Command codes carried in the command field.
    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] offset_x;
        logic signed [COORD_BITS-1:0] offset_y;
        logic [SIZE_BITS-1:0]         size_x;
        logic [SIZE_BITS-1:0]         size_y;
        logic [TYPE_BITS-1:0]         obj_type;
    } box_t;

    // One result transaction.
    typedef struct packed {
        logic [SLOT_BITS-1:0] earlier_slot;
        logic [SLOT_BITS-1:0] new_slot;
        logic                 hit;
        logic                 last;
        logic                 full_res;
    } pair_t;

    // One stored collider: centre and extent of a box.
    typedef struct packed {
        logic signed [CENTRE_BITS-1:0] centre_x;
        logic signed [CENTRE_BITS-1:0] centre_y;
        logic [SIZE_BITS-1:0]          size_x;
        logic [SIZE_BITS-1:0]          size_y;
        logic [TYPE_BITS-1:0]          obj_type;
    } entry_t;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        RES_HIT,
        RES_FINAL,
        RES_CLEAR,
        RES_FULL
    } res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clear;
        logic      insert;
        logic      rd_first;
        logic      rd_next;
        logic      load;
        res_kind_t kind;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic store_full;
        logic store_empty;
        logic last_entry;
        logic match;
    } dp_status_t;

endpackage

@@ src/aabb_pair_collision_finder_unit.sv @@
// Top level of the box pair collision finder: joins controller and datapath.
// Depends on apcf_pkg, apcf_ctrl and apcf_datapath.
//
//  channel | direction | signals                          | payload
//  box     | in        | box_valid, box_stall, box_data   | apcf_pkg::box_t
//  pair    | out       | pair_valid, pair_stall, pair_data | apcf_pkg::pair_t
//
// A clear or a refused insert gives one result.
// An insert reads each stored box in turn from the collider memory through its single
// registered port, and gives one result per hit and then a final result.
// Reset empties the store at once; stored entries need no clearing.
// A stalled result holds the scan at the next hit; one transaction is worked on at a time.
`timescale 1ns / 1ps

module aabb_pair_collision_finder_unit #(
    parameter int MAX_BOXES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    output logic             box_stall,
    input  apcf_pkg::box_t   box_data,
    output logic             pair_valid,
    input  logic             pair_stall,
    output apcf_pkg::pair_t  pair_data
);

    apcf_pkg::ctl_cmd_t   cmd;
    apcf_pkg::dp_status_t status;

    apcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_command (box_data.command),
        .box_stall   (box_stall),
        .status      (status),
        .cmd         (cmd)
    );

    apcf_datapath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_data   (box_data),
        .cmd        (cmd),
        .status     (status),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_data  (pair_data)
    );

    // An input transaction is only taken when the result register can take its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && !box_stall) |-> (!pair_valid || !pair_stall))
        else $error("input accepted while the result register is blocked");

    // A clear gives its closing result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && !box_stall && box_data.command == apcf_pkg::CMD_CLEAR)
        |=> (pair_valid && pair_data.last && !pair_data.hit && !pair_data.full_res))
        else $error("clear did not give a closing result");

    // A hit result never closes a transaction and never reports a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && pair_data.hit) |-> (!pair_data.last && !pair_data.full_res))
        else $error("hit result carries end or full flag");

    // A refused insert carries no slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && pair_data.full_res)
        |-> (pair_data.last && pair_data.new_slot == '0 && pair_data.earlier_slot == '0))
        else $error("full result carries slot numbers");

endmodule

@@ src/apcf_datapath.sv @@
// Datapath of the box pair collision finder: collider memory, counters, overlap
// test and the result register.
// Depends on apcf_pkg.
`timescale 1ns / 1ps

module apcf_datapath #(
    parameter int MAX_BOXES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  apcf_pkg::box_t      box_data,
    input  apcf_pkg::ctl_cmd_t  cmd,
    output apcf_pkg::dp_status_t status,
    output logic                pair_valid,
    input  logic                pair_stall,
    output apcf_pkg::pair_t     pair_data
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int CB    = apcf_pkg::CENTRE_BITS;
    localparam int CW    = apcf_pkg::COORD_BITS;
    localparam int SB    = apcf_pkg::SIZE_BITS;

    apcf_pkg::entry_t mem [MAX_BOXES];

    logic [CNT_W-1:0] count_reg,    count_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    apcf_pkg::entry_t new_reg;
    apcf_pkg::entry_t rd_data_reg;
    apcf_pkg::entry_t new_entry;
    logic             pair_valid_reg, pair_valid_next;
    apcf_pkg::pair_t  pair_reg,       pair_next;

    logic signed [CB:0]   diff_x, diff_y;
    logic [CB:0]          abs_x, abs_y;
    logic [CB+1:0]        dbl_x, dbl_y;
    logic [SB:0]          sum_x, sum_y;
    logic                 overlap_x, overlap_y;

    // The centre is position plus offset, one bit wider so that it never wraps.
    always_comb
    begin
        new_entry.centre_x = {box_data.pos_x[CW-1], box_data.pos_x}
                           + {box_data.offset_x[CW-1], box_data.offset_x};
        new_entry.centre_y = {box_data.pos_y[CW-1], box_data.pos_y}
                           + {box_data.offset_y[CW-1], box_data.offset_y};
        new_entry.size_x   = box_data.size_x;
        new_entry.size_y   = box_data.size_y;
        new_entry.obj_type = box_data.obj_type;
    end

    // Fill count of the store.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Read address for the scan: slot zero first, then one slot per step.
    assign rd_en   = cmd.rd_first || cmd.rd_next;
    assign rd_addr = cmd.rd_first ? '0 : scan_idx_reg + IDX_W'(1);

    // Collider memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem[count_reg[IDX_W-1:0]] <= new_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Registers of the box under test and the scan position.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            new_reg  <= new_entry;
            slot_reg <= count_reg[IDX_W-1:0];
        end
        if (rd_en)
        begin
            scan_idx_reg <= rd_addr;
        end
    end

    // Overlap test: doubled centre distance against the summed full sizes.
    always_comb
    begin
        diff_x = {rd_data_reg.centre_x[CB-1], rd_data_reg.centre_x}
               - {new_reg.centre_x[CB-1], new_reg.centre_x};
        diff_y = {rd_data_reg.centre_y[CB-1], rd_data_reg.centre_y}
               - {new_reg.centre_y[CB-1], new_reg.centre_y};
        abs_x  = diff_x[CB] ? (CB+1)'(-diff_x) : diff_x;
        abs_y  = diff_y[CB] ? (CB+1)'(-diff_y) : diff_y;
        dbl_x  = {abs_x, 1'b0};
        dbl_y  = {abs_y, 1'b0};
        sum_x  = {1'b0, rd_data_reg.size_x} + {1'b0, new_reg.size_x};
        sum_y  = {1'b0, rd_data_reg.size_y} + {1'b0, new_reg.size_y};
        overlap_x = dbl_x < (CB+2)'(sum_x);
        overlap_y = dbl_y < (CB+2)'(sum_y);
    end

    // Status towards the controller.
    always_comb
    begin
        status.out_free    = !pair_valid_reg || !pair_stall;
        status.store_full  = count_reg == CNT_W'(MAX_BOXES);
        status.store_empty = count_reg == '0;
        status.last_entry  = scan_idx_reg == slot_reg - IDX_W'(1);
        status.match       = (rd_data_reg.obj_type != new_reg.obj_type)
                           && overlap_x && overlap_y;
    end

    // Result register contents for each kind of result.
    always_comb
    begin
        pair_next       = pair_reg;
        pair_valid_next = pair_valid_reg && pair_stall;
        if (cmd.load)
        begin
            pair_valid_next = 1'b1;
            pair_next       = '0;
            case (cmd.kind)
                apcf_pkg::RES_HIT:
                begin
                    pair_next.earlier_slot = apcf_pkg::SLOT_BITS'(scan_idx_reg);
                    pair_next.new_slot     = apcf_pkg::SLOT_BITS'(slot_reg);
                    pair_next.hit          = 1'b1;
                end
                apcf_pkg::RES_FINAL:
                begin
                    pair_next.new_slot = apcf_pkg::SLOT_BITS'(slot_reg);
                    pair_next.last     = 1'b1;
                end
                apcf_pkg::RES_CLEAR:
                begin
                    pair_next.last = 1'b1;
                end
                default:
                begin
                    pair_next.last     = 1'b1;
                    pair_next.full_res = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair_valid = pair_valid_reg;
    assign pair_data  = pair_reg;

endmodule

@@ src/apcf_ctrl.sv @@
// Controller of the box pair collision finder: sequences clear, insert, the
// scan of the stored colliders and the issue of results.
// Depends on apcf_pkg.
`timescale 1ns / 1ps

module apcf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 box_valid,
    input  logic                 box_command,
    output logic                 box_stall,
    input  apcf_pkg::dp_status_t status,
    output apcf_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = apcf_pkg::RES_HIT;
        box_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                box_stall = !status.out_free;
                if (box_valid && status.out_free)
                begin
                    if (box_command == apcf_pkg::CMD_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                        cmd.load  = 1'b1;
                        cmd.kind  = apcf_pkg::RES_CLEAR;
                    end
                    else if (status.store_full)
                    begin
                        cmd.load = 1'b1;
                        cmd.kind = apcf_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        if (status.store_empty)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = ST_COMPARE;
                        end
                    end
                end
            end
            ST_COMPARE:
            begin
                // A hit holds the scan until the result register is free.
                if (!status.match || status.out_free)
                begin
                    if (status.match)
                    begin
                        cmd.load = 1'b1;
                        cmd.kind = apcf_pkg::RES_HIT;
                    end
                    if (status.last_entry)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.kind   = apcf_pkg::RES_FINAL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sim/aabb_pair_collision_finder_unit_test.sv @@
// Self-checking testbench for the box pair collision finder: directed rows, then
// clustered random boxes with random idling, checked against a behavioural predictor.
// Depends on apcf_pkg and aabb_pair_collision_finder_unit.
`timescale 1ns / 1ps

module aabb_pair_collision_finder_unit_test;

    localparam int MAX_BOXES     = 32;
    localparam int RAND_ITEMS    = 94;
    localparam int TAIL_ITEMS    = 20;
    localparam int FILL_INSERTS  = MAX_BOXES + 2;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 2 * MAX_BOXES + 8;
    localparam int QUIET_LIMIT   = 4 * (LONG_HOLD + 2 * MAX_BOXES + 64);
    localparam int REPORT_LIMIT  = 10;

    // The sole result of a clear, and the final result of an insert into an empty store.
    localparam apcf_pkg::pair_t LAST_ONLY = '{earlier_slot: '0, new_slot: '0, hit: 1'b0,
                                             last: 1'b1, full_res: 1'b0};

    typedef struct {
        apcf_pkg::box_t  item;
        bit              typed;
        apcf_pkg::pair_t want;
    } stim_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            box_valid;
    logic            box_stall;
    apcf_pkg::box_t  box_data;
    logic            pair_valid;
    logic            pair_stall;
    apcf_pkg::pair_t pair_data;

    stim_row_t       stim_rows[$];
    apcf_pkg::pair_t pending_pairs[$];

    // Predictor state: one entry per stored collider.
    longint ctr_x [MAX_BOXES];
    longint ctr_y [MAX_BOXES];
    longint ext_x [MAX_BOXES];
    longint ext_y [MAX_BOXES];
    int     kind  [MAX_BOXES];
    int     stored;

    // Stimulus controls shared between processes.
    int tx_idle_pct;
    int rx_idle_pct;
    bit quiet_tail;
    bit long_hold_req;

    // Run statistics.
    int n_items;
    int n_clears;
    int n_results;
    int n_hits;
    int n_refused;
    int n_mismatch;
    int quiet_cycles;

    aabb_pair_collision_finder_unit #(
        .MAX_BOXES(MAX_BOXES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .box_valid(box_valid),
        .box_stall(box_stall),
        .box_data(box_data),
        .pair_valid(pair_valid),
        .pair_stall(pair_stall),
        .pair_data(pair_data)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Strict overlap on one axis, in doubled-distance form so nothing is halved.
    function automatic bit axis_overlaps(longint ca, longint cb, longint sa, longint sb);
        longint d;
        d = (ca > cb) ? ca - cb : cb - ca;
        return (2 * d) < (sa + sb);
    endfunction

    // Works out every result an input transaction causes and updates the store.
    task automatic find_pairs(input apcf_pkg::box_t b, ref apcf_pkg::pair_t found[$]);
        longint          cx;
        longint          cy;
        apcf_pkg::pair_t r;
        int              slot;
        r = '0;
        if (b.command == apcf_pkg::CMD_CLEAR)
        begin
            stored = 0;
            r.last = 1'b1;
            found  = {found, r};
            return;
        end
        if (stored >= MAX_BOXES)
        begin
            r.last     = 1'b1;
            r.full_res = 1'b1;
            found      = {found, r};
            return;
        end
        cx   = longint'($signed(b.pos_x)) + longint'($signed(b.offset_x));
        cy   = longint'($signed(b.pos_y)) + longint'($signed(b.offset_y));
        slot = stored;
        // Scan stored boxes in slot order; equal types never collide.
        for (int i = 0; i < slot; i++)
        begin
            if (kind[i] != int'(b.obj_type) &&
                axis_overlaps(ctr_x[i], cx, ext_x[i], longint'(b.size_x)) &&
                axis_overlaps(ctr_y[i], cy, ext_y[i], longint'(b.size_y)))
            begin
                r              = '0;
                r.earlier_slot = apcf_pkg::SLOT_BITS'(i);
                r.new_slot     = apcf_pkg::SLOT_BITS'(slot);
                r.hit          = 1'b1;
                found          = {found, r};
            end
        end
        ctr_x[slot] = cx;
        ctr_y[slot] = cy;
        ext_x[slot] = longint'(b.size_x);
        ext_y[slot] = longint'(b.size_y);
        kind[slot]  = int'(b.obj_type);
        stored      = slot + 1;
        r           = '0;
        r.new_slot  = apcf_pkg::SLOT_BITS'(slot);
        r.last      = 1'b1;
        found       = {found, r};
    endtask

    function automatic void add_row(logic cmd, int px, int py, int ox, int oy,
                                     int sx, int sy, int ty, bit typed,
                                     apcf_pkg::pair_t want);
        stim_row_t row;
        row.item.command  = cmd;
        row.item.pos_x    = 16'(px);
        row.item.pos_y    = 16'(py);
        row.item.offset_x = 16'(ox);
        row.item.offset_y = 16'(oy);
        row.item.size_x   = 16'(sx);
        row.item.size_y   = 16'(sy);
        row.item.obj_type = 8'(ty);
        row.typed         = typed;
        row.want          = want;
        stim_rows         = {stim_rows, row};
    endfunction

    // A box near a cluster centre, so that overlaps are common.
    function automatic apcf_pkg::box_t cluster_box(int cx0, int cy0);
        apcf_pkg::box_t b;
        b.command  = apcf_pkg::CMD_INSERT;
        b.pos_x    = 16'(cx0 + int'($urandom_range(0, 512)) - 256);
        b.pos_y    = 16'(cy0 + int'($urandom_range(0, 512)) - 256);
        b.offset_x = 16'(int'($urandom_range(0, 128)) - 64);
        b.offset_y = 16'(int'($urandom_range(0, 128)) - 64);
        b.size_x   = 16'($urandom_range(0, 600));
        b.size_y   = 16'($urandom_range(0, 600));
        b.obj_type = 8'($urandom_range(0, 3));
        return b;
    endfunction

    // Offers one transaction, waits for it to be taken, then queues its expected results.
    task automatic issue(input apcf_pkg::box_t b, input bit typed, input apcf_pkg::pair_t want);
        apcf_pkg::pair_t found[$];
        box_valid <= 1'b1;
        box_data  <= b;
        @(posedge clk);
        while (box_stall)
            @(posedge clk);
        find_pairs(b, found);
        if (typed)
            pending_pairs = {pending_pairs, want};
        else
            foreach (found[k])
                pending_pairs = {pending_pairs, found[k]};
        n_items++;
        if (b.command == apcf_pkg::CMD_CLEAR)
            n_clears++;
    endtask

    task automatic idle_gap();
        if (!quiet_tail && int'($urandom_range(0, 99)) < tx_idle_pct)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // Stops offering until every expected result has arrived and the block has settled.
    task automatic drain_results();
        box_valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    // Result stalls: random bursts, plus one long hold-off on request.
    initial
    begin : pair_stall_gen
        int hold_left;
        hold_left  = 0;
        pair_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pair_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                pair_stall   <= 1'b1;
            end
            else if (!quiet_tail && int'($urandom_range(0, 99)) < rx_idle_pct)
            begin
                hold_left   = $urandom_range(0, 13);
                pair_stall <= 1'b1;
            end
            else
                pair_stall <= 1'b0;
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : pair_check
        apcf_pkg::pair_t want;
        if (rst_n && pair_valid && !pair_stall)
        begin
            n_results++;
            n_hits    += pair_data.hit;
            n_refused += pair_data.full_res;
            if (pending_pairs.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: slot %0d/%0d hit %b last %b full %b",
                             $realtime, pair_data.earlier_slot, pair_data.new_slot,
                             pair_data.hit, pair_data.last, pair_data.full_res);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (pair_data.earlier_slot !== want.earlier_slot ||
                    pair_data.new_slot !== want.new_slot ||
                    pair_data.hit !== want.hit ||
                    pair_data.last !== want.last ||
                    pair_data.full_res !== want.full_res)
                begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_LIMIT)
                        $display({"[%0t] result mismatch: expected %0d/%0d %b%b%b, ",
                                  "got %0d/%0d %b%b%b"},
                                 $realtime, want.earlier_slot, want.new_slot,
                                 want.hit, want.last, want.full_res,
                                 pair_data.earlier_slot, pair_data.new_slot,
                                 pair_data.hit, pair_data.last, pair_data.full_res);
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a transaction for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (box_valid && !box_stall) || (pair_valid && !pair_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        apcf_pkg::box_t b;
        int             n_rand;
        int             cx0;
        int             cy0;
        int             run_len;
        int             roll;
        rst_n         = 1'b0;
        box_valid     = 1'b0;
        box_data      = '0;
        tx_idle_pct   = 25;
        rx_idle_pct   = 25;
        quiet_tail    = 1'b0;
        long_hold_req = 1'b0;
        stored        = 0;
        n_rand        = 0;

        // Directed rows: extremes, equal types, zero sizes and the strict edge.
        add_row(apcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, 32767, 32767, 32767, 32767, 16, 16, 1, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, -32768, -32768, -32768, -32768, 65535, 65535, 2,
                1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 32767, 32767, 32767, 32767, 32, 32, 1, 1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 32767, 32767, 32767, 32767, 0, 0, 3, 1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 32767, 32767, 32767, 32767, 0, 0, 4, 1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 32767, 32767, 32759, 32767, 0, 16, 5, 1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, -32768, 32767, 32767, -32768, 65535, 65535, 0,
                1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 0, 0, 0, 0, 1, 1, 255, 1'b0, '0);
        add_row(apcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, 0, 0, 0, 0, 100, 100, 7, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, 10, -10, -10, 10, 100, 100, 8, 1'b0, '0);
        add_row(apcf_pkg::CMD_INSERT, 0, 0, 0, 0, 100, 100, 7, 1'b0, '0);
        add_row(apcf_pkg::CMD_CLEAR, -1, -1, -1, -1, 65535, 65535, 255, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, -1, -1, -1, -1, 65535, 65535, 255, 1'b1, LAST_ONLY);
        add_row(apcf_pkg::CMD_INSERT, -1, -1, 0, 0, 0, 0, 0, 1'b0, '0);

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            issue(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
            idle_gap();
        end
        drain_results();

        // Fill the store past capacity with back-to-back inserts while results are held off.
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b1;
        b             = '0;
        b.command     = apcf_pkg::CMD_CLEAR;
        issue(b, 1'b0, '0);
        cx0 = int'($urandom_range(0, 60000)) - 30000;
        cy0 = int'($urandom_range(0, 60000)) - 30000;
        for (int k = 0; k < FILL_INSERTS; k++)
            issue(cluster_box(cx0, cy0), 1'b0, '0);
        n_rand = FILL_INSERTS + 1;
        drain_results();

        // Random runs: mostly clustered inserts after a clear, with some noise.
        while (n_rand < RAND_ITEMS)
        begin
            tx_idle_pct = 15 * int'($urandom_range(0, 2));
            rx_idle_pct = 15 * int'($urandom_range(0, 2));
            cx0         = int'($urandom_range(0, 60000)) - 30000;
            cy0         = int'($urandom_range(0, 60000)) - 30000;
            run_len     = $urandom_range(1, 14);
            if ($urandom_range(0, 4) != 0)
            begin
                b         = '0;
                b.command = apcf_pkg::CMD_CLEAR;
                issue(b, 1'b0, '0);
                n_rand++;
                idle_gap();
            end
            for (int k = 0; k < run_len && n_rand < RAND_ITEMS; k++)
            begin
                quiet_tail = (n_rand >= RAND_ITEMS - TAIL_ITEMS);
                roll       = $urandom_range(0, 99);
                if (roll < 84)
                    b = cluster_box(cx0, cy0);
                else if (roll < 94)
                begin
                    b.command  = 1'($urandom_range(0, 1));
                    b.pos_x    = 16'($urandom);
                    b.pos_y    = 16'($urandom);
                    b.offset_x = 16'($urandom);
                    b.offset_y = 16'($urandom);
                    b.size_x   = 16'($urandom);
                    b.size_y   = 16'($urandom);
                    b.obj_type = 8'($urandom);
                end
                else
                begin
                    b         = '0;
                    b.command = apcf_pkg::CMD_CLEAR;
                end
                issue(b, 1'b0, '0);
                n_rand++;
                idle_gap();
            end
        end
        drain_results();

        $display("Covered %0d transactions (%0d clears) and %0d results: %0d pairs, %0d refusals.",
                 n_items, n_clears, n_results, n_hits, n_refused);
        $display("Included a %0d-cycle result hold-off and a full store; %0d mismatches.",
                 LONG_HOLD, n_mismatch);
        if (n_mismatch == 0 && pending_pairs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
